// File: rtl/ordered_list_insert_delete_unit_macros.svh
// assertion macros for the ordered list unit
`ifndef ORDERED_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define OLID_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("olid assertion failed");

// next-cycle implication
`define OLID_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("olid assertion failed");

`endif

// File: rtl/olid_pkg.sv
// types and codes shared by the ordered list unit
`default_nettype none

package olid_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_RM_HEAD = 3'd1;
  localparam logic [2:0] OP_RM_TAIL = 3'd2;
  localparam logic [2:0] OP_RM_VAL  = 3'd3;
  localparam logic [2:0] OP_RD_IDX  = 3'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_BADINDEX = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] value;
    logic [3:0]               index;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] item_value;
    logic [4:0]               entry_count;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/ordered_list_insert_delete_unit.sv
// Ordered list unit: bounded list of signed 32-bit values in insertion order.
//
// Command channel: req_i is taken at a rising edge with start high and busy
// low. Opcodes append at the tail, remove the head, remove the tail, remove
// the first entry equal to a value, or read the entry at an index.
// Result channel: each command gives exactly one result on rsp_o, valid for
// the single cycle in which done_o is high; the receiver cannot stall it.
// Append, unknown opcodes and errors found when a command is taken (full,
// empty, index out of range) give their result in the next cycle without
// raising busy. Remove head, remove tail and read index pass through the
// registered read of the entry store. Remove by value runs a search that
// reads one entry per cycle up to the match, then a shift that moves each
// later entry up one place per cycle through the single write port of the
// store. The store is addressed as a ring from a head pointer, so removing
// the head moves no data. Reset clears the count and head pointer; the list
// is empty afterwards and the store contents are left as they are.
`default_nettype none

module ordered_list_insert_delete_unit
  import olid_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      done_o,
  output rsp_t      rsp_o
);

  `include "ordered_list_insert_delete_unit_macros.svh"

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [4:0]  CAP_LOW5 = 5'(CAPACITY);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  olid_ctrl #(
    .Capacity(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  olid_mem #(
    .Depth(CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  `OLID_ASSERT_IMP(a_err_value_zero, done_o && rsp_o.status != ST_OK, rsp_o.item_value == '0)
  `OLID_ASSERT_NXT(a_cmd_progress, start && !busy, done_o || busy)
  `OLID_ASSERT_IMP(a_full_count, done_o && rsp_o.status == ST_FULL, rsp_o.entry_count == CAP_LOW5)
  `OLID_ASSERT_IMP(a_write_owned, mem_we, busy || start)

endmodule

`default_nettype wire

// File: rtl/olid_mem.sv
// entry store: one write port, one read port with registered read data
`default_nettype none

module olid_mem
  import olid_pkg::*;
#(
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/olid_ctrl.sv
// sequencer: circular head pointer, count, search and shift over the entry store
`default_nettype none

module olid_ctrl
  import olid_pkg::*;
#(
  parameter int unsigned Capacity = 16,
  localparam int unsigned AW      = $clog2(Capacity),
  localparam int unsigned CW      = $clog2(Capacity + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire req_t              req_i,
  output logic                   done_o,
  output rsp_t                   rsp_o,
  output logic                   mem_we_o,
  output logic      [AW-1:0]     mem_waddr_o,
  output logic      [DATA_W-1:0] mem_wdata_o,
  output logic      [AW-1:0]     mem_raddr_o,
  input  wire logic [DATA_W-1:0] mem_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_SHIFT
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic [2:0]        op_q, op_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic [DATA_W-1:0] got_q, got_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;

  logic              empty, full, idx_ok;
  logic [CW+3:0]     idx_ext;

  // logical position to physical address, one wrap at most
  function automatic logic [AW-1:0] phys(logic [AW-1:0] h, logic [CW-1:0] i);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, i};
    if (s >= (CW + 1)'(Capacity)) begin
      s = s - (CW + 1)'(Capacity);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [4:0] cnt5(logic [CW-1:0] c);
    logic [CW+4:0] e;
    e = {5'b0, c};
    return e[4:0];
  endfunction

  assign empty   = (count_q == '0);
  assign full    = (count_q == CW'(Capacity));
  assign idx_ext = {{CW{1'b0}}, req_i.index};
  assign idx_ok  = (idx_ext < {4'b0, count_q});

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    op_d        = op_q;
    key_d       = key_q;
    got_d       = got_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = req_i.value;
    mem_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d = req_i.opcode;
          case (req_i.opcode) inside
            OP_APPEND: begin
              done_d = 1'b1;
              if (full) begin
                rsp_d = '{status: ST_FULL, item_value: '0, entry_count: cnt5(count_q)};
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = phys(head_q, count_q);
                count_d     = count_q + CW'(1);
                rsp_d = '{status: ST_OK, item_value: '0, entry_count: cnt5(count_d)};
              end
            end
            OP_RM_HEAD, OP_RM_TAIL, OP_RM_VAL: begin
              if (empty) begin
                done_d = 1'b1;
                rsp_d = '{status: ST_EMPTY, item_value: '0, entry_count: cnt5(count_q)};
              end else if (req_i.opcode == OP_RM_TAIL) begin
                mem_raddr_o = phys(head_q, count_q - CW'(1));
                state_d     = S_READ;
              end else if (req_i.opcode == OP_RM_HEAD) begin
                mem_raddr_o = phys(head_q, '0);
                state_d     = S_READ;
              end else begin
                mem_raddr_o = phys(head_q, '0);
                ptr_d       = '0;
                key_d       = req_i.value;
                state_d     = S_SEARCH;
              end
            end
            OP_RD_IDX: begin
              if (empty) begin
                done_d = 1'b1;
                rsp_d = '{status: ST_EMPTY, item_value: '0, entry_count: cnt5(count_q)};
              end else if (!idx_ok) begin
                done_d = 1'b1;
                rsp_d = '{status: ST_BADINDEX, item_value: '0,
                          entry_count: cnt5(count_q)};
              end else begin
                mem_raddr_o = phys(head_q, idx_ext[CW-1:0]);
                state_d     = S_READ;
              end
            end
            default: begin
              done_d = 1'b1;
              rsp_d = '{status: ST_OK, item_value: '0, entry_count: cnt5(count_q)};
            end
          endcase
        end
      end

      S_READ: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (op_q == OP_RM_HEAD) begin
          head_d  = phys(head_q, CW'(1));
          count_d = count_q - CW'(1);
        end else if (op_q == OP_RM_TAIL) begin
          count_d = count_q - CW'(1);
        end
        rsp_d = '{status: ST_OK, item_value: mem_rdata_i, entry_count: cnt5(count_d)};
      end

      // data for position ptr_q arrives, next position already on the way
      S_SEARCH: begin
        mem_raddr_o = phys(head_q, ptr_q + CW'(1));
        if (mem_rdata_i == key_q) begin
          got_d   = mem_rdata_i;
          ptr_d   = ptr_q + CW'(1);
          state_d = S_SHIFT;
        end else if (ptr_q == count_q - CW'(1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          rsp_d = '{status: ST_NOTFOUND, item_value: '0, entry_count: cnt5(count_q)};
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end

      // move entry ptr_q up one place while fetching the one after it
      S_SHIFT: begin
        if (ptr_q < count_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = phys(head_q, ptr_q - CW'(1));
          mem_wdata_o = mem_rdata_i;
          mem_raddr_o = phys(head_q, ptr_q + CW'(1));
          ptr_d       = ptr_q + CW'(1);
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          count_d = count_q - CW'(1);
          rsp_d = '{status: ST_OK, item_value: got_q, entry_count: cnt5(count_d)};
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      ptr_q   <= '0;
      op_q    <= OP_APPEND;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      op_q    <= op_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    got_q <= got_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// File: tb/olid_checker.sv
`timescale 1ns / 1ps
// watches the command and result channels of the ordered list unit and checks every result

module olid_checker
  import olid_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire logic  busy_i,
  input  wire req_t  req_i,
  input  wire logic  done_i,
  input  wire rsp_t  rsp_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned full_o,
  output int unsigned miss_o
);

  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int unsigned              list_len;
  rsp_t                     expected_rsp_q [$];
  rsp_t                     oldest;

  // next list state and the result it gives, kept in step with every accepted item
  function automatic rsp_t apply_list_op(req_t cmd);
    rsp_t        res;
    int unsigned pos;
    res.status     = ST_OK;
    res.item_value = '0;
    case (cmd.opcode)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_mem[list_len] = cmd.value;
          list_len++;
        end
      end
      OP_RM_HEAD: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.item_value = list_mem[0];
          for (int unsigned i = 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
        end
      end
      OP_RM_TAIL: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.item_value = list_mem[list_len-1];
          list_len--;
        end
      end
      OP_RM_VAL: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // first match wins
          pos = list_len;
          for (int unsigned i = 0; i < list_len; i++) begin
            if (pos == list_len && list_mem[i] == cmd.value) pos = i;
          end
          if (pos == list_len) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.item_value = list_mem[pos];
            for (int unsigned i = pos + 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
            list_len--;
          end
        end
      end
      OP_RD_IDX: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (cmd.index >= list_len) begin
          res.status = ST_BADINDEX;
        end else begin
          res.item_value = list_mem[cmd.index];
        end
      end
      default: begin
      end
    endcase
    res.entry_count = 5'(list_len);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      expected_rsp_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
      checked_o  = 0;
      full_o     = 0;
      miss_o     = 0;
    end else begin
      if (start_i === 1'b1 && busy_i === 1'b0) expected_rsp_q.push_back(apply_list_op(req_i));
      if (done_i !== 1'b0) begin
        if (expected_rsp_q.size() == 0) begin
          fail_cnt_o++;
          $display("%0t: result with none expected: status %0d value %0d count %0d",
                   $time, rsp_i.status, rsp_i.item_value, rsp_i.entry_count);
        end else begin
          oldest = expected_rsp_q.pop_front();
          checked_o++;
          if (oldest.status == ST_FULL) full_o++;
          if (oldest.status == ST_NOTFOUND) miss_o++;
          if (rsp_i.status !== oldest.status) begin
            fail_cnt_o++;
            $display("%0t: status expected %0d actual %0d",
                     $time, oldest.status, rsp_i.status);
          end
          if (rsp_i.item_value !== oldest.item_value) begin
            fail_cnt_o++;
            $display("%0t: item_value expected %0d actual %0d",
                     $time, oldest.item_value, rsp_i.item_value);
          end
          if (rsp_i.entry_count !== oldest.entry_count) begin
            fail_cnt_o++;
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, oldest.entry_count, rsp_i.entry_count);
          end
        end
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench top for the ordered list unit: clock, reset, command stimulus and verdict

module tb
  import olid_pkg::*;
();

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned N_RANDOM     = 1750;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned TAIL_CYCLES  = 2 * CAPACITY + 20;
  localparam logic [2:0]  OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  OP_RSVD_LAST  = 3'd7;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req    = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked;
  int unsigned full_hits;
  int unsigned search_misses;

  int unsigned n_sent;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  int unsigned mode_left;
  bit          filling;
  logic signed [DATA_W-1:0] recent_vals [8];
  int unsigned recent_wr;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  ordered_list_insert_delete_unit #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  olid_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req),
    .done_i     (done_o),
    .rsp_i      (rsp_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked),
    .full_o     (full_hits),
    .miss_o     (search_misses)
  );

  function automatic req_t mk(logic [2:0] op, logic signed [DATA_W-1:0] val, logic [3:0] idx);
    req_t r;
    r.opcode = op;
    r.value  = val;
    r.index  = idx;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones, and bursts with none
  function int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // small values give duplicates, so first-match removal gets exercised
  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(0, 7)) - 3;
      default: return $urandom;
    endcase
  endfunction

  function req_t rand_req();
    req_t        r;
    int unsigned w;
    r.value = rand_value();
    r.index = 4'($urandom_range(0, 15));
    w = $urandom_range(0, 99);
    if (w < 3) begin
      r.opcode = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    end else if (w < 18) begin
      r.opcode = OP_RD_IDX;
    end else if (filling ? (w < 70) : (w < 35)) begin
      r.opcode = OP_APPEND;
    end else begin
      case ($urandom_range(0, 2))
        0:       r.opcode = OP_RM_HEAD;
        1:       r.opcode = OP_RM_TAIL;
        default: r.opcode = OP_RM_VAL;
      endcase
    end
    // search mostly for values that were appended lately
    if (r.opcode == OP_RM_VAL && recent_wr > 0 && $urandom_range(0, 3) != 0)
      r.value = recent_vals[$urandom_range(0, (recent_wr < 8 ? recent_wr : 8) - 1)];
    return r;
  endfunction

  task issue(input req_t cmd);
    int unsigned gap;
    req_t        noise;
    @(negedge clk_i);
    start <= 1'b1;
    req   <= cmd;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    n_sent++;
    if (cmd.opcode == OP_APPEND) begin
      recent_vals[recent_wr % 8] = cmd.value;
      recent_wr++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      noise.opcode = 3'($urandom);
      noise.value  = $urandom;
      noise.index  = 4'($urandom);
      @(negedge clk_i);
      start <= 1'b0;
      req   <= noise;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    n_sent     = 0;
    burst_left = 0;
    mode_left  = 0;
    filling    = 1'b0;
    recent_wr  = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list cases, and an unknown opcode with every bit set
    issue(mk(OP_RD_IDX, '0, '0));
    issue(mk(OP_RM_HEAD, '0, '0));
    issue(mk(OP_RM_TAIL, '0, '0));
    issue(mk(OP_RM_VAL, VAL_MIN, '0));
    issue(mk(OP_RSVD_LAST, '1, '1));
    // fill up, extremes first, then one append too many
    for (int i = 0; i < CAPACITY; i++)
      issue(mk(OP_APPEND, i == 0 ? VAL_MIN : i == 1 ? VAL_MAX : i == 2 ? 0 :
                          i == 3 ? -1 : i * 3 - 20, 4'(i)));
    issue(mk(OP_APPEND, 99, '0));
    issue(mk(OP_RD_IDX, '0, 4'd15));
    issue(mk(OP_RD_IDX, '0, '0));
    issue(mk(OP_RM_VAL, '0, '0));
    issue(mk(OP_RM_VAL, 12345, '0));
    issue(mk(OP_RM_HEAD, '0, '0));
    issue(mk(OP_RM_TAIL, '0, '0));
    issue(mk(OP_RD_IDX, '0, 4'd15));
    issue(mk(OP_RSVD_FIRST, '0, '0));

    // random part drifts between filling and draining the list
    for (int n = 0; n < N_RANDOM; n++) begin
      if (mode_left == 0) begin
        filling   = !filling;
        mode_left = $urandom_range(30, 120);
      end
      mode_left--;
      issue(rand_req());
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d commands sent, %0d results checked, %0d mismatches",
             n_sent, checked, fail_cnt);
    $display("appends refused on a full list: %0d, value searches without a match: %0d",
             full_hits, search_misses);
    if (fail_cnt == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: ordered_list_insert_delete_unit.f
+incdir+rtl
rtl/olid_pkg.sv
rtl/olid_mem.sv
rtl/olid_ctrl.sv
rtl/ordered_list_insert_delete_unit.sv
tb/olid_checker.sv
tb/tb.sv
